// ===== rtl/core/ppi8255_pkg.sv =====
package ppi8255_pkg;

    // Bus access kinds
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Port select codes
    localparam logic [1:0] PORT_A    = 2'd0;
    localparam logic [1:0] PORT_B    = 2'd1;
    localparam logic [1:0] PORT_C    = 2'd2;
    localparam logic [1:0] PORT_CTRL = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_PRINTER_READY     = 2'd0;
    localparam logic [1:0] REG_EXPANSION_LINE    = 2'd1;
    localparam logic [1:0] REG_REFRESH_50HZ      = 2'd2;
    localparam logic [1:0] REG_MANUFACTURER_CODE = 2'd3;

    // Mode word bits (mode 0 direction controls and the mode set flag)
    localparam int MODE_CL_IN  = 0;
    localparam int MODE_B_IN   = 1;
    localparam int MODE_CH_IN  = 3;
    localparam int MODE_A_IN   = 4;
    localparam int MODE_SET    = 7;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    // One result item
    typedef struct packed {
        logic [7:0] read_data;
        logic       sound_write_strobe;
        logic [7:0] sound_write_data;
        logic       sound_control_update;
        logic       sound_bdir_out;
        logic       sound_bc1_out;
        logic       key_select_update;
        logic [3:0] key_line_out;
        logic       tape_motor_out;
        logic       tape_write_out;
    } t_result;

endpackage

// ===== rtl/core/parallel_port_interface_8255_unit.sv =====
// Mode-0 three-port parallel interface, one CPU bus access per item.
//
// Input channel (i_in_valid / o_in_stall): opcode, port select, write byte
// and the live input lines sampled with the access. Output channel
// (o_out_valid / i_out_stall): one result item per accepted item with the
// read byte, sound chip strobes, keyboard select and tape outputs.
// The result is registered: it is loaded into the output register at the
// accepting edge, or into the skid register while the output is held.
// Throughput is one item per cycle while o_in_stall is low; the decode and
// latch update are a few gates between the input handshake and the result register.
// When the receiver stalls, one further item is caught in a skid register;
// o_in_stall is then raised until the skid entry drains, so no item is lost.
// Reset (synchronous, active low) clears the port latches, mode word (all
// ports output), tape bits and both valid flags, and loads the registers
// with printer_ready 0, expansion_line 0, refresh_50hz 1 and
// manufacturer_code 7. The APB port (pready always high) reads and writes
// the four registers at byte addresses 0, 4, 8 and 12.
module parallel_port_interface_8255_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_opcode,
    input  logic [1:0]                         i_port_select,
    input  logic [7:0]                         i_write_data,
    input  logic                               i_vsync_level,
    input  logic                               i_tape_read_level,
    input  logic [7:0]                         i_sound_read_data,
    input  logic                               i_sound_bdir_now,
    input  logic                               i_sound_bc1_now,
    input  logic [3:0]                         i_key_line_now,
    // output channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [7:0]                         o_read_data,
    output logic                               o_sound_write_strobe,
    output logic [7:0]                         o_sound_write_data,
    output logic                               o_sound_control_update,
    output logic                               o_sound_bdir_out,
    output logic                               o_sound_bc1_out,
    output logic                               o_key_select_update,
    output logic [3:0]                         o_key_line_out,
    output logic                               o_tape_motor_out,
    output logic                               o_tape_write_out,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ppi8255_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [ppi8255_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [ppi8255_pkg::CFG_DATA_W-1:0] prdata,
    output logic                               pready
);
    import ppi8255_pkg::*;

    // configuration registers
    logic       r_printer_ready;
    logic       r_expansion_line;
    logic       r_refresh_50hz;
    logic [2:0] r_manufacturer_code;

    // port state
    logic [7:0] r_latch_a, n_latch_a;
    logic [7:0] r_latch_b, n_latch_b;
    logic [7:0] r_latch_c, n_latch_c;
    logic [7:0] r_mode, n_mode;
    logic       r_motor, n_motor;
    logic       r_tape_out, n_tape_out;

    // output and skid registers
    t_result    r_out, r_skid, n_result;
    logic       r_out_valid, r_skid_valid;

    logic       in_accept, out_take, cfg_write;
    logic       a_in, b_in, ch_in, cl_in;
    logic       drive_c;
    logic [2:0] bit_sel;
    logic [7:0] port_c_rd;

    assign a_in  = r_mode[MODE_A_IN];
    assign b_in  = r_mode[MODE_B_IN];
    assign ch_in = r_mode[MODE_CH_IN];
    assign cl_in = r_mode[MODE_CL_IN];

    assign in_accept  = i_in_valid && !r_skid_valid;
    assign out_take   = r_out_valid && !i_out_stall;
    assign o_in_stall = r_skid_valid;

    // APB: always ready, decode on word address
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            REG_PRINTER_READY:     prdata[0]   = r_printer_ready;
            REG_EXPANSION_LINE:    prdata[0]   = r_expansion_line;
            REG_REFRESH_50HZ:      prdata[0]   = r_refresh_50hz;
            REG_MANUFACTURER_CODE: prdata[2:0] = r_manufacturer_code;
            default:               prdata      = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_printer_ready     <= 1'b0;
            r_expansion_line    <= 1'b0;
            r_refresh_50hz      <= 1'b1;
            r_manufacturer_code <= 3'd7;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                REG_PRINTER_READY:     r_printer_ready     <= pwdata[0];
                REG_EXPANSION_LINE:    r_expansion_line    <= pwdata[0];
                REG_REFRESH_50HZ:      r_refresh_50hz      <= pwdata[0];
                REG_MANUFACTURER_CODE: r_manufacturer_code <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    // port C read value, built from the direction bits
    assign port_c_rd = {ch_in ? {i_sound_bdir_now, i_sound_bc1_now, r_tape_out, r_motor}
                              : r_latch_c[7:4],
                        cl_in ? i_key_line_now : r_latch_c[3:0]};

    assign bit_sel = i_write_data[3:1];

    // access decode and latch update
    always_comb begin
        n_latch_a  = r_latch_a;
        n_latch_b  = r_latch_b;
        n_latch_c  = r_latch_c;
        n_mode     = r_mode;
        n_motor    = r_motor;
        n_tape_out = r_tape_out;
        n_result   = '0;
        drive_c    = 1'b0;

        if (i_opcode == OP_READ) begin
            unique case (i_port_select)
                PORT_A: n_result.read_data = a_in ? i_sound_read_data : r_latch_a;
                PORT_B: n_result.read_data = b_in
                    ? {i_tape_read_level, r_printer_ready, r_expansion_line,
                       r_refresh_50hz, r_manufacturer_code, i_vsync_level}
                    : r_latch_b;
                PORT_C: n_result.read_data = port_c_rd;
                default: n_result.read_data = '0;
            endcase
        end else begin
            unique case (i_port_select)
                PORT_A: begin
                    n_latch_a = i_write_data;
                    if (!a_in) begin
                        n_result.sound_write_strobe = 1'b1;
                        n_result.sound_write_data   = i_write_data;
                    end
                end
                PORT_B: n_latch_b = i_write_data;
                PORT_C: begin
                    n_latch_c = i_write_data;
                    drive_c   = 1'b1;
                end
                default: begin
                    if (i_write_data[MODE_SET]) begin
                        n_mode    = i_write_data;
                        n_latch_a = '0;
                        n_latch_b = '0;
                        n_latch_c = '0;
                    end else if (!ch_in && !cl_in) begin
                        n_latch_c[bit_sel] = i_write_data[0];
                        drive_c            = 1'b1;
                    end
                end
            endcase
        end

        // port C drive to keyboard, tape and sound chip
        if (drive_c) begin
            if (!cl_in) begin
                n_result.key_select_update = 1'b1;
                n_result.key_line_out      = n_latch_c[3:0];
            end
            if (!ch_in) begin
                n_motor                        = n_latch_c[4];
                n_tape_out                     = n_latch_c[5];
                n_result.sound_control_update  = 1'b1;
                n_result.sound_bdir_out        = n_latch_c[7];
                n_result.sound_bc1_out         = n_latch_c[6];
                n_result.sound_write_strobe    = 1'b1;
                n_result.sound_write_data      = n_latch_a;
            end
        end

        n_result.tape_motor_out = n_motor;
        n_result.tape_write_out = n_tape_out;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latch_a  <= '0;
            r_latch_b  <= '0;
            r_latch_c  <= '0;
            r_mode     <= '0;
            r_motor    <= 1'b0;
            r_tape_out <= 1'b0;
        end else if (in_accept) begin
            r_latch_a  <= n_latch_a;
            r_latch_b  <= n_latch_b;
            r_latch_c  <= n_latch_c;
            r_mode     <= n_mode;
            r_motor    <= n_motor;
            r_tape_out <= n_tape_out;
        end
    end

    // output register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || out_take) begin
                r_out_valid <= r_skid_valid || in_accept;
            end
            if (in_accept && r_out_valid && !out_take) begin
                r_skid_valid <= 1'b1;
            end else if (out_take) begin
                r_skid_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_take) begin
            r_out <= r_skid_valid ? r_skid : n_result;
        end
        if (in_accept && r_out_valid && !out_take) begin
            r_skid <= n_result;
        end
    end

    assign o_out_valid            = r_out_valid;
    assign o_read_data            = r_out.read_data;
    assign o_sound_write_strobe   = r_out.sound_write_strobe;
    assign o_sound_write_data     = r_out.sound_write_data;
    assign o_sound_control_update = r_out.sound_control_update;
    assign o_sound_bdir_out       = r_out.sound_bdir_out;
    assign o_sound_bc1_out        = r_out.sound_bc1_out;
    assign o_key_select_update    = r_out.key_select_update;
    assign o_key_line_out         = r_out.key_line_out;
    assign o_tape_motor_out       = r_out.tape_motor_out;
    assign o_tape_write_out       = r_out.tape_write_out;

    // skid entry only exists behind a held output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid with empty output register");

    // an item accepted against a stalled output lands in the skid entry
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && r_out_valid && i_out_stall) |=> r_skid_valid)
        else $error("item accepted under stall was not caught");

    // mode load clears the port latches
    a_mode_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_opcode == OP_WRITE && i_port_select == PORT_CTRL
         && i_write_data[MODE_SET])
        |=> (r_latch_a == 8'd0 && r_latch_b == 8'd0 && r_latch_c == 8'd0))
        else $error("control mode load left a latch set");

    // write results never carry read data, sound lines idle without update
    a_result_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.sound_control_update)
        |-> (!r_out.sound_bdir_out && !r_out.sound_bc1_out))
        else $error("sound control lines driven without update");

    a_strobe_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.sound_write_strobe) |-> (r_out.read_data == 8'd0))
        else $error("write result carries read data");

endmodule
